>>> sv/pps_pkg.sv
`default_nettype none

package pps_pkg;

	localparam int LIMIT_W = 20;
	localparam int SIGNAL_W = 16;

	localparam logic [SIGNAL_W-1:0] SSDV_SIGNAL_RESET = 16'd1000;
	localparam logic [LIMIT_W-1:0] STOP_DELAY_RESET = 20'd15000;
	localparam logic [LIMIT_W-1:0] MAX_SESSION_RESET = 20'd600000;

	localparam logic [1:0] REG_SSDV_SIGNAL = 2'd0;
	localparam logic [1:0] REG_STOP_DELAY = 2'd1;
	localparam logic [1:0] REG_MAX_SESSION = 2'd2;

	localparam logic [1:0] OP_TICK = 2'd0;

	// duration class bounds, whole minutes of 60000 ticks
	localparam int DUR_1MIN = 60000;
	localparam int DUR_2MIN = 120000;
	localparam int DUR_4MIN = 240000;
	localparam int DUR_6MIN = 360000;
	localparam int DUR_8MIN = 480000;
	localparam int DUR_10MIN = 600000;

	localparam logic [4:0] BEACON_NONE = 5'd0;
	localparam logic [4:0] BEACON_COMMS = 5'd1;
	localparam logic [4:0] BEACON_PHOTO = 5'd8;
	localparam logic [4:0] BEACON_SSDV = 5'd15;
	localparam logic [4:0] BEACON_OC = 5'd22;

	typedef enum logic [6:0] {
		PH_OFF    = 7'b0000001,
		PH_WAIT   = 7'b0000010,
		PH_PHOTO  = 7'b0000100,
		PH_COMMS  = 7'b0001000,
		PH_SIGNAL = 7'b0010000,
		PH_SSDV   = 7'b0100000,
		PH_DELAY  = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_PHOTO = 2'd1,
		ACT_SSDV  = 2'd2,
		ACT_COMMS = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		SR_NONE      = 2'd0,
		SR_ACCEPTED  = 2'd1,
		SR_BUSY      = 2'd2,
		SR_LOW_POWER = 2'd3
	} start_res_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       sd_req_a;
		logic       sd_req_b;
		logic       sd_req_c;
		logic       overcurrent_n;
		logic       pwr_ok;
	} item_t;

	typedef struct packed {
		logic       power_on;
		logic       mode_line_high;
		logic [1:0] start_result;
		logic [2:0] session_state;
		logic [4:0] beacon_code;
		logic       timeout_seen;
		logic       overcurrent_seen;
	} result_t;

	typedef struct packed {
		logic [1:0]         index;
		logic [LIMIT_W-1:0] value;
	} cfg_t;

	typedef struct packed {
		logic [SIGNAL_W-1:0] ssdv_signal;
		logic [LIMIT_W-1:0]  stop_delay;
		logic [LIMIT_W-1:0]  max_session;
	} cfg_regs_t;

	typedef struct packed {
		phase_t phase;
		act_t   act;
		logic   mode;
		logic   timeout;
		logic   oc;
	} ctrl_t;

	function automatic logic [2:0] phase_code(phase_t p);
		logic [2:0] c;
		case (p)
			PH_OFF:    c = 3'd0;
			PH_WAIT:   c = 3'd1;
			PH_PHOTO:  c = 3'd2;
			PH_COMMS:  c = 3'd3;
			PH_SIGNAL: c = 3'd4;
			PH_SSDV:   c = 3'd5;
			PH_DELAY:  c = 3'd6;
			default:   c = 3'd0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> sv/pps_stream_if.sv
`default_nettype none

interface pps_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/pps_step.sv
`default_nettype none

module pps_step #(
	parameter int TIMER_BITS = 20
) (
	input  wire pps_pkg::item_t          item,
	input  wire pps_pkg::cfg_regs_t      regs,
	input  wire pps_pkg::ctrl_t          cur,
	input  wire logic [TIMER_BITS-1:0]   elapsed,
	input  wire logic [TIMER_BITS-1:0]   phase_cnt,
	input  wire logic [TIMER_BITS-1:0]   last_dur,
	output pps_pkg::ctrl_t          nxt,
	output logic [TIMER_BITS-1:0]   elapsed_nxt,
	output logic [TIMER_BITS-1:0]   phase_nxt,
	output logic [TIMER_BITS-1:0]   last_nxt,
	output pps_pkg::result_t        result
);

	localparam int CW = (TIMER_BITS > pps_pkg::LIMIT_W) ? TIMER_BITS : pps_pkg::LIMIT_W;
	localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

	logic [1:0]           votes;
	logic                 shut;
	logic                 oc_now;
	logic                 force_timeout;
	pps_pkg::start_res_t  start_res;
	logic [CW-1:0]        dur_x;
	logic [2:0]           dur_class;
	logic [4:0]           beacon_base;

	assign votes = {1'b0, item.sd_req_a} + {1'b0, item.sd_req_b} + {1'b0, item.sd_req_c};
	assign shut = votes[1];
	assign oc_now = !item.overcurrent_n;

	always_comb begin
		nxt = cur;
		last_nxt = last_dur;
		start_res = pps_pkg::SR_NONE;
		elapsed_nxt = (elapsed == CNT_MAX) ? elapsed : elapsed + 1'b1;
		phase_nxt = (phase_cnt == CNT_MAX) ? phase_cnt : phase_cnt + 1'b1;

		if (item.opcode != pps_pkg::OP_TICK) begin
			if (cur.phase != pps_pkg::PH_OFF) begin
				start_res = pps_pkg::SR_BUSY;
			end else if (!item.pwr_ok) begin
				start_res = pps_pkg::SR_LOW_POWER;
			end else begin
				start_res = pps_pkg::SR_ACCEPTED;
				nxt.act = pps_pkg::act_t'(item.opcode);
				nxt.mode = (pps_pkg::act_t'(item.opcode) == pps_pkg::ACT_COMMS);
				nxt.timeout = 1'b0;
				nxt.oc = 1'b0;
				nxt.phase = pps_pkg::PH_WAIT;
				elapsed_nxt = '0;
			end
		end

		force_timeout = (CW'(elapsed_nxt) > CW'(regs.max_session))
			&& (nxt.phase != pps_pkg::PH_OFF);

		if (oc_now) begin
			nxt.phase = pps_pkg::PH_OFF;
			last_nxt = elapsed_nxt;
			nxt.oc = 1'b1;
		end else if (force_timeout) begin
			nxt.phase = pps_pkg::PH_OFF;
			last_nxt = elapsed_nxt;
			nxt.timeout = 1'b1;
		end else begin
			case (nxt.phase)
				pps_pkg::PH_OFF: begin
				end
				pps_pkg::PH_WAIT: begin
					if (!shut) begin
						case (nxt.act)
							pps_pkg::ACT_PHOTO: nxt.phase = pps_pkg::PH_PHOTO;
							pps_pkg::ACT_COMMS: nxt.phase = pps_pkg::PH_COMMS;
							pps_pkg::ACT_SSDV: begin
								phase_nxt = '0;
								nxt.phase = pps_pkg::PH_SIGNAL;
							end
							default: nxt.phase = pps_pkg::PH_OFF;
						endcase
					end
				end
				pps_pkg::PH_PHOTO, pps_pkg::PH_COMMS, pps_pkg::PH_SSDV: begin
					if (shut) begin
						nxt.phase = pps_pkg::PH_DELAY;
						phase_nxt = '0;
					end
				end
				pps_pkg::PH_SIGNAL: begin
					if (CW'(phase_nxt) > CW'(regs.ssdv_signal)) begin
						nxt.mode = 1'b1;
						nxt.phase = pps_pkg::PH_SSDV;
					end
				end
				pps_pkg::PH_DELAY: begin
					if (CW'(phase_nxt) > CW'(regs.stop_delay)) begin
						nxt.phase = pps_pkg::PH_OFF;
						last_nxt = elapsed_nxt;
					end
				end
				default: nxt.phase = pps_pkg::PH_OFF;
			endcase
		end
	end

	assign dur_x = CW'(last_nxt);

	always_comb begin
		if (dur_x < CW'(pps_pkg::DUR_1MIN))       dur_class = 3'd0;
		else if (dur_x < CW'(pps_pkg::DUR_2MIN))  dur_class = 3'd1;
		else if (dur_x < CW'(pps_pkg::DUR_4MIN))  dur_class = 3'd2;
		else if (dur_x < CW'(pps_pkg::DUR_6MIN))  dur_class = 3'd3;
		else if (dur_x < CW'(pps_pkg::DUR_8MIN))  dur_class = 3'd4;
		else if (dur_x < CW'(pps_pkg::DUR_10MIN)) dur_class = 3'd5;
		else                                      dur_class = 3'd6;
	end

	always_comb begin
		if (nxt.oc) begin
			beacon_base = pps_pkg::BEACON_OC;
		end else begin
			case (nxt.act)
				pps_pkg::ACT_COMMS: beacon_base = pps_pkg::BEACON_COMMS;
				pps_pkg::ACT_PHOTO: beacon_base = pps_pkg::BEACON_PHOTO;
				pps_pkg::ACT_SSDV:  beacon_base = pps_pkg::BEACON_SSDV;
				default:            beacon_base = pps_pkg::BEACON_NONE;
			endcase
		end
	end

	always_comb begin
		result.power_on = (nxt.phase != pps_pkg::PH_OFF);
		result.mode_line_high = nxt.mode;
		result.start_result = start_res;
		result.session_state = pps_pkg::phase_code(nxt.phase);
		result.beacon_code = (beacon_base == pps_pkg::BEACON_NONE) ? pps_pkg::BEACON_NONE
			: beacon_base + {2'b00, dur_class};
		result.timeout_seen = nxt.timeout;
		result.overcurrent_seen = nxt.oc;
	end

endmodule

`default_nettype wire

>>> sv/payload_power_session_supervisor.sv
// Payload power session supervisor.
// item: one transaction per millisecond tick, carrying the start opcode, the
//   three shutdown vote lines, the active-low overcurrent line and the
//   power-adequate flag.
// result: one transaction per tick with power, mode line, start outcome,
//   session state, beacon code and the timeout/overcurrent flags, all taken
//   after that tick's update.
// cfg: register writes (index 0 SSDV signal hold, 1 shutdown delay,
//   2 session limit); always ready, other indexes are dropped.
// An accepted item goes into the item register, then one pass of the session
//   step into the result register.
// Throughput is one tick per cycle while the receiver does not stall; the
//   session state registers close the loop from one tick to the next.
// Reset clears the session to off with zeroed counters and flags and loads
//   the default register values.
// When the receiver stalls, the result register holds; if the item register
//   is empty one more item is taken into it, then item.ready stays low until
//   the result is taken.
`default_nettype none

module payload_power_session_supervisor #(
	parameter int TIMER_BITS = 20
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pps_stream_if.sink   item,
	pps_stream_if.source result,
	pps_stream_if.sink   cfg
);

	pps_pkg::item_t     item_s1;
	logic               item_valid_s1;
	pps_pkg::result_t   res_q;
	logic               res_valid_q;
	pps_pkg::cfg_regs_t regs_q;
	pps_pkg::ctrl_t     ctrl_q;
	logic [TIMER_BITS-1:0] elapsed_q;
	logic [TIMER_BITS-1:0] phase_cnt_q;
	logic [TIMER_BITS-1:0] last_dur_q;

	pps_pkg::ctrl_t     ctrl_nxt;
	logic [TIMER_BITS-1:0] elapsed_nxt;
	logic [TIMER_BITS-1:0] phase_nxt;
	logic [TIMER_BITS-1:0] last_nxt;
	pps_pkg::result_t   res_nxt;

	logic advance;
	logic item_acc;
	logic fire;

	assign advance = !res_valid_q || result.ready;
	assign item.ready = !item_valid_s1 || advance;
	assign item_acc = item.valid && item.ready;
	assign fire = item_valid_s1 && advance;

	assign result.valid = res_valid_q;
	assign result.data = res_q;
	assign cfg.ready = 1'b1;

	pps_step #(.TIMER_BITS(TIMER_BITS)) u_step (
		.item        (item_s1),
		.regs        (regs_q),
		.cur         (ctrl_q),
		.elapsed     (elapsed_q),
		.phase_cnt   (phase_cnt_q),
		.last_dur    (last_dur_q),
		.nxt         (ctrl_nxt),
		.elapsed_nxt (elapsed_nxt),
		.phase_nxt   (phase_nxt),
		.last_nxt    (last_nxt),
		.result      (res_nxt)
	);

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_s1 <= item.data;
		end
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			ctrl_q <= '{phase: pps_pkg::PH_OFF, act: pps_pkg::ACT_NONE,
				mode: 1'b0, timeout: 1'b0, oc: 1'b0};
			elapsed_q <= '0;
			phase_cnt_q <= '0;
			last_dur_q <= '0;
			regs_q.ssdv_signal <= pps_pkg::SSDV_SIGNAL_RESET;
			regs_q.stop_delay <= pps_pkg::STOP_DELAY_RESET;
			regs_q.max_session <= pps_pkg::MAX_SESSION_RESET;
		end else begin
			item_valid_s1 <= item_acc || (item_valid_s1 && !advance);
			res_valid_q <= fire || (res_valid_q && !result.ready);
			if (fire) begin
				ctrl_q <= ctrl_nxt;
				elapsed_q <= elapsed_nxt;
				phase_cnt_q <= phase_nxt;
				last_dur_q <= last_nxt;
			end
			if (cfg.valid) begin
				case (cfg.data.index)
					pps_pkg::REG_SSDV_SIGNAL:
						regs_q.ssdv_signal <= cfg.data.value[pps_pkg::SIGNAL_W-1:0];
					pps_pkg::REG_STOP_DELAY:
						regs_q.stop_delay <= cfg.data.value;
					pps_pkg::REG_MAX_SESSION:
						regs_q.max_session <= cfg.data.value;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire
